### src/trwq_pkg.sv
// Shared types and constants for the timed register write queue.
// No dependencies; imported by every module of the block.
package trwq_pkg;

  // Ring depth of the original queue; one slot is always kept free
  localparam int QUEUE_DEPTH = 64;
  localparam int CAPACITY    = QUEUE_DEPTH - 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int ADDR_W  = 5;
  localparam int VALUE_W = 8;
  localparam int DELAY_W = 24;
  localparam int TICK_W  = 16;
  // Countdown spans -(2^16-1) .. 2^24-1
  localparam int CD_W    = DELAY_W + 1;

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(22);

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic [DELAY_W-1:0] delay;
  } entry_t;

  // Control from the sequencer to the cell chain
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [CNT_W-1:0] load_idx;
  } chain_ctl_t;

endpackage

### src/timed_register_write_queue.sv
// Timed register write queue: a shifting chain of write slots and a countdown.
// Depends on trwq_pkg, trwq_chain and trwq_cell.
// Enqueue, clear, ignored modes and a tick on an empty queue release no writes.
// Other ticks enter the pop state in the cycle after the transfer; writes are then
// offered while the countdown is at or below zero; receiver stalls hold the release.
// Synchronous active-low reset empties the queue, zeroes the countdown and
// loads 22 into cycles_per_tick; slot contents are not reset.
module timed_register_write_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [trwq_pkg::ADDR_W-1:0]   in_reg_addr,
  input  logic [trwq_pkg::VALUE_W-1:0]  in_write_value,
  input  logic [trwq_pkg::DELAY_W-1:0]  in_delay_cycles,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trwq_pkg::ADDR_W-1:0]   out_addr,
  output logic [trwq_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_last_write,
  input  logic                          cfg_wr_en,
  input  logic [trwq_pkg::TICK_W-1:0]   cfg_wr_data
);
  import trwq_pkg::*;

  state_t                   st_r, st_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [CD_W-1:0]   cd_r, cd_nxt;
  logic [TICK_W-1:0]        cpt_r;

  chain_ctl_t               ctl;
  entry_t                   ld_ent, head_ent;
  logic [DELAY_W-1:0]       next_delay;

  logic                     in_xfer, out_xfer, pop_due, has_items;
  logic signed [CD_W-1:0]   cd_after_pop;
  mode_t                    mode;

  assign mode      = mode_t'(in_mode);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign has_items = (count_r != '0);
  assign pop_due   = (st_r == ST_POP) && has_items && (cd_r[CD_W-1] || (cd_r == '0));
  assign cd_after_pop = cd_r + $signed({1'b0, next_delay});

  assign ld_ent.addr  = in_reg_addr;
  assign ld_ent.value = in_write_value;
  assign ld_ent.delay = in_delay_cycles;

  trwq_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .ld_ent     (ld_ent),
    .head_ent   (head_ent),
    .next_delay (next_delay)
  );

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer && (mode == MODE_TICK) && has_items) begin
          st_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (!pop_due) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = (st_r == ST_IDLE);
    out_valid = pop_due;
  end

  assign out_addr       = head_ent.addr;
  assign out_value      = head_ent.value;
  // Final write when the queue drains or the next delay keeps the countdown positive
  assign out_last_write = (count_r == CNT_W'(1)) || (cd_after_pop > 0);

  // Queue fill and countdown
  always_comb begin
    count_nxt    = count_r;
    cd_nxt       = cd_r;
    ctl.shift    = 1'b0;
    ctl.load     = 1'b0;
    ctl.load_idx = count_r;
    if (in_xfer) begin
      unique case (mode)
        MODE_ENQ: begin
          if (count_r != CNT_W'(CAPACITY)) begin
            ctl.load  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (!has_items) begin
              cd_nxt = $signed({1'b0, in_delay_cycles});
            end
          end
        end
        MODE_TICK: begin
          if (has_items) begin
            cd_nxt = cd_r - $signed({{(CD_W-TICK_W){1'b0}}, cpt_r});
          end
        end
        MODE_CLEAR: begin
          count_nxt = '0;
          cd_nxt    = '0;
        end
        MODE_NONE: ;
        default: ;
      endcase
    end else if (out_xfer) begin
      // Drop the head and charge the next entry's delay
      ctl.shift = 1'b1;
      count_nxt = count_r - CNT_W'(1);
      cd_nxt    = (count_r == CNT_W'(1)) ? '0 : cd_after_pop;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      cd_r    <= '0;
      cpt_r   <= TICK_RESET;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      cd_r    <= cd_nxt;
      if (cfg_wr_en) begin
        cpt_r <= cfg_wr_data;
      end
    end
  end

endmodule

### src/trwq_cell.sv
// One queue slot: holds an entry, takes its upper neighbor's entry on a shift.
// Depends on trwq_pkg.
module trwq_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  trwq_pkg::entry_t nb_ent,
  input  trwq_pkg::entry_t ld_ent,
  output trwq_pkg::entry_t ent
);
  import trwq_pkg::*;

  entry_t ent_r;

  // Advance toward the head, or capture a new write at the tail
  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r <= nb_ent;
    end else if (load) begin
      ent_r <= ld_ent;
    end
  end

  assign ent = ent_r;

endmodule

### src/trwq_chain.sv
// Row of queue cells; cell 0 is the head of the queue.
// Depends on trwq_pkg and trwq_cell.
module trwq_chain (
  input  logic                       clk,
  input  trwq_pkg::chain_ctl_t       ctl,
  input  trwq_pkg::entry_t           ld_ent,
  output trwq_pkg::entry_t           head_ent,
  output logic [trwq_pkg::DELAY_W-1:0] next_delay
);
  import trwq_pkg::*;

  entry_t ents [CAPACITY+1];

  // Slot past the last cell feeds nothing useful
  assign ents[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    trwq_cell u_cell (
      .clk    (clk),
      .shift  (ctl.shift),
      .load   (ctl.load && (ctl.load_idx == CNT_W'(i))),
      .nb_ent (ents[i+1]),
      .ld_ent (ld_ent),
      .ent    (ents[i])
    );
  end

  assign head_ent   = ents[0];
  assign next_delay = ents[1].delay;

endmodule

### src/trwq_checker.sv
// Port-level checks for the timed register write queue, bound to the top level.
// Depends on trwq_pkg and timed_register_write_queue.
module trwq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [trwq_pkg::ADDR_W-1:0]   out_addr,
  input logic [trwq_pkg::VALUE_W-1:0]  out_value,
  input logic                          out_last_write
);
  import trwq_pkg::*;

  // Hold a pending result steady until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_addr) && $stable(out_value)
      && $stable(out_last_write))
    else $error("result changed while stalled");

  // No new item while a tick still releases writes
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during write release");

  // Release stops after the final write of a tick
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_write |=> !out_valid)
    else $error("write released after final write");

  // Only a tick can release writes
  a_notick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != MODE_TICK) |=> !out_valid)
    else $error("write released without a tick");

  // Nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind timed_register_write_queue trwq_checker u_trwq_checker (.*);
